// File: rtl/core/jsv_pkg.sv
// jsv_pkg: types, codes and character helpers for the JSON stream validator
// no dependencies; imported by jsv_step and json_stream_validator
`default_nettype none

package jsv_pkg;

	// parse phases
	localparam logic [4:0] PH_VALUE       = 5'd0;
	localparam logic [4:0] PH_ARR_FIRST   = 5'd1;
	localparam logic [4:0] PH_OBJ_FIRST   = 5'd2;
	localparam logic [4:0] PH_KEY         = 5'd3;
	localparam logic [4:0] PH_COLON       = 5'd4;
	localparam logic [4:0] PH_KEY_BODY    = 5'd5;
	localparam logic [4:0] PH_KEY_ESC     = 5'd6;
	localparam logic [4:0] PH_KEY_HEX     = 5'd7;
	localparam logic [4:0] PH_STR_BODY    = 5'd8;
	localparam logic [4:0] PH_STR_ESC     = 5'd9;
	localparam logic [4:0] PH_STR_HEX     = 5'd10;
	localparam logic [4:0] PH_LIT_N       = 5'd11;
	localparam logic [4:0] PH_LIT_T       = 5'd12;
	localparam logic [4:0] PH_LIT_F       = 5'd13;
	localparam logic [4:0] PH_NUM_SIGN    = 5'd14;
	localparam logic [4:0] PH_NUM_INT     = 5'd15;
	localparam logic [4:0] PH_NUM_FRAC    = 5'd16;
	localparam logic [4:0] PH_NUM_EXP     = 5'd17;
	localparam logic [4:0] PH_NUM_EXPSIGN = 5'd18;
	localparam logic [4:0] PH_NUM_EXPDIG  = 5'd19;
	localparam logic [4:0] PH_AFTER       = 5'd20;

	// token kinds
	localparam logic [3:0] TK_WS        = 4'd0;
	localparam logic [3:0] TK_OBJ_OPEN  = 4'd1;
	localparam logic [3:0] TK_OBJ_CLOSE = 4'd2;
	localparam logic [3:0] TK_ARR_OPEN  = 4'd3;
	localparam logic [3:0] TK_ARR_CLOSE = 4'd4;
	localparam logic [3:0] TK_KEY_QUOTE = 4'd5;
	localparam logic [3:0] TK_KEY_BYTE  = 4'd6;
	localparam logic [3:0] TK_KEY_END   = 4'd7;
	localparam logic [3:0] TK_STR_QUOTE = 4'd8;
	localparam logic [3:0] TK_STR_BYTE  = 4'd9;
	localparam logic [3:0] TK_STR_END   = 4'd10;
	localparam logic [3:0] TK_NUMBER    = 4'd11;
	localparam logic [3:0] TK_LIT_BYTE  = 4'd12;
	localparam logic [3:0] TK_LIT_DONE  = 4'd13;
	localparam logic [3:0] TK_COLON     = 4'd14;
	localparam logic [3:0] TK_COMMA     = 4'd15;

	// status codes
	localparam logic [3:0] ST_PROGRESS   = 4'd0;
	localparam logic [3:0] ST_ACCEPTED   = 4'd1;
	localparam logic [3:0] ST_BAD_LIT    = 4'd2;
	localparam logic [3:0] ST_EXP_DIGIT  = 4'd3;
	localparam logic [3:0] ST_EXP_KEY    = 4'd4;
	localparam logic [3:0] ST_BAD_ESC    = 4'd5;
	localparam logic [3:0] ST_BAD_HEX    = 4'd6;
	localparam logic [3:0] ST_UNTERM_STR = 4'd7;
	localparam logic [3:0] ST_EXP_COLON  = 4'd8;
	localparam logic [3:0] ST_EXP_OBJ    = 4'd9;
	localparam logic [3:0] ST_EXP_ARR    = 4'd10;
	localparam logic [3:0] ST_TRAILING   = 4'd11;
	localparam logic [3:0] ST_TOO_DEEP   = 4'd12;

	// characters
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_LOW_E  = 8'h65;
	localparam logic [7:0] CH_UP_E   = 8'h45;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;

	typedef struct packed {
		logic [4:0] phase;
		logic [2:0] lit_step;
		logic [2:0] hex_rem;
		logic [3:0] err;
	} parse_state_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic obj;
	} nest_op_t;

	typedef struct packed {
		logic [3:0] kind;
		logic       ended;
		logic [3:0] status;
	} token_info_t;

	function automatic logic is_ws(input logic [7:0] b);
		return b == 8'h20 || b == 8'h09 || b == 8'h0D || b == 8'h0A;
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return b >= 8'h30 && b <= 8'h39;
	endfunction

	function automatic logic is_hex(input logic [7:0] b);
		return is_digit(b) || (b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46);
	endfunction

	function automatic logic is_simple_esc(input logic [7:0] b);
		return b == CH_QUOTE || b == CH_BSLASH || b == CH_SLASH || b == 8'h62 ||
			b == 8'h66 || b == 8'h6E || b == 8'h72 || b == 8'h74;
	endfunction

	// literal words: null, true, false
	function automatic logic [7:0] lit_char(input logic [1:0] w, input logic [2:0] idx);
		logic [7:0] c;
		c = CH_NUL;
		case (w)
			2'd0: begin
				case (idx)
					3'd0: c = 8'h6E;
					3'd1: c = 8'h75;
					3'd2: c = 8'h6C;
					3'd3: c = 8'h6C;
					default: c = CH_NUL;
				endcase
			end
			2'd1: begin
				case (idx)
					3'd0: c = 8'h74;
					3'd1: c = 8'h72;
					3'd2: c = 8'h75;
					3'd3: c = 8'h65;
					default: c = CH_NUL;
				endcase
			end
			2'd2: begin
				case (idx)
					3'd0: c = 8'h66;
					3'd1: c = 8'h61;
					3'd2: c = 8'h6C;
					3'd3: c = 8'h73;
					3'd4: c = 8'h65;
					default: c = CH_NUL;
				endcase
			end
			default: c = CH_NUL;
		endcase
		return c;
	endfunction

	function automatic logic [2:0] lit_len(input logic [1:0] w);
		return (w == 2'd2) ? 3'd5 : 3'd4;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/jsv_step.sv
// jsv_step: grammar step for one document byte, next parse state and token
// uses jsv_pkg; the nesting stack and level live in json_stream_validator
`default_nettype none

module jsv_step (
	input  wire logic [7:0]           text_byte,
	input  wire jsv_pkg::parse_state_t cur,
	input  wire logic                 at_top,
	input  wire logic                 at_limit,
	input  wire logic                 top_obj,
	output jsv_pkg::parse_state_t     nxt,
	output jsv_pkg::nest_op_t         op,
	output jsv_pkg::token_info_t      info
);
	import jsv_pkg::*;

	logic [7:0] b;
	logic [3:0] kind;
	logic [3:0] fcode;
	logic       ended;
	logic       accepted;
	logic       done;
	logic       start;
	logic       after;
	logic       key;
	logic [1:0] lw;

	assign b = text_byte;

	always_comb begin
		nxt      = cur;
		op       = '0;
		kind     = TK_WS;
		fcode    = ST_PROGRESS;
		ended    = 1'b0;
		accepted = 1'b0;
		done     = 1'b0;
		start    = 1'b0;
		after    = 1'b0;
		key      = 1'b0;
		lw       = 2'(cur.phase - PH_LIT_N);

		if (cur.err == ST_PROGRESS) begin
			// number phases, may fall through to the after-value handling
			if (cur.phase == PH_NUM_SIGN || cur.phase == PH_NUM_EXPSIGN) begin
				done = 1'b1;
				if (!is_digit(b)) begin
					fcode = ST_EXP_DIGIT;
				end else begin
					nxt.phase = (cur.phase == PH_NUM_SIGN) ? PH_NUM_INT : PH_NUM_EXPDIG;
					kind = TK_NUMBER;
				end
			end else if (cur.phase == PH_NUM_EXP) begin
				done = 1'b1;
				if (b == CH_PLUS || b == CH_MINUS) begin
					nxt.phase = PH_NUM_EXPSIGN;
					kind = TK_NUMBER;
				end else if (is_digit(b)) begin
					nxt.phase = PH_NUM_EXPDIG;
					kind = TK_NUMBER;
				end else begin
					fcode = ST_EXP_DIGIT;
				end
			end else if (cur.phase == PH_NUM_INT || cur.phase == PH_NUM_FRAC ||
					cur.phase == PH_NUM_EXPDIG) begin
				if (is_digit(b)) begin
					done = 1'b1;
					kind = TK_NUMBER;
				end else if (cur.phase == PH_NUM_INT && b == CH_DOT) begin
					done = 1'b1;
					nxt.phase = PH_NUM_FRAC;
					kind = TK_NUMBER;
				end else if (cur.phase != PH_NUM_EXPDIG && (b == CH_LOW_E || b == CH_UP_E)) begin
					done = 1'b1;
					nxt.phase = PH_NUM_EXP;
					kind = TK_NUMBER;
				end else begin
					ended = 1'b1;
					nxt.phase = PH_AFTER;
					after = 1'b1;
				end
			end

			if (!done && !after) begin
				case (cur.phase)
					PH_ARR_FIRST: begin
						if (is_ws(b)) begin
							kind = TK_WS;
						end else if (b == CH_RBRACK) begin
							op.pop = 1'b1;
							nxt.phase = PH_AFTER;
							kind = TK_ARR_CLOSE;
						end else begin
							start = 1'b1;
						end
					end
					PH_OBJ_FIRST, PH_KEY: begin
						if (is_ws(b)) begin
							kind = TK_WS;
						end else if (cur.phase == PH_OBJ_FIRST && b == CH_RBRACE) begin
							op.pop = 1'b1;
							nxt.phase = PH_AFTER;
							kind = TK_OBJ_CLOSE;
						end else if (b == CH_QUOTE) begin
							nxt.phase = PH_KEY_BODY;
							kind = TK_KEY_QUOTE;
						end else begin
							fcode = ST_EXP_KEY;
						end
					end
					PH_COLON: begin
						if (is_ws(b)) begin
							kind = TK_WS;
						end else if (b == CH_COLON) begin
							nxt.phase = PH_VALUE;
							kind = TK_COLON;
						end else begin
							fcode = ST_EXP_COLON;
						end
					end
					PH_KEY_BODY, PH_KEY_ESC, PH_KEY_HEX,
					PH_STR_BODY, PH_STR_ESC, PH_STR_HEX: begin
						key = (cur.phase == PH_KEY_BODY || cur.phase == PH_KEY_ESC ||
							cur.phase == PH_KEY_HEX);
						if (cur.phase == PH_KEY_ESC || cur.phase == PH_STR_ESC) begin
							if (is_simple_esc(b)) begin
								nxt.phase = key ? PH_KEY_BODY : PH_STR_BODY;
								kind = key ? TK_KEY_BYTE : TK_STR_BYTE;
							end else if (b == 8'h75) begin
								nxt.phase = key ? PH_KEY_HEX : PH_STR_HEX;
								nxt.hex_rem = 3'd4;
								kind = key ? TK_KEY_BYTE : TK_STR_BYTE;
							end else begin
								fcode = ST_BAD_ESC;
							end
						end else if (cur.phase == PH_KEY_HEX || cur.phase == PH_STR_HEX) begin
							if (!is_hex(b)) begin
								fcode = ST_BAD_HEX;
							end else begin
								if (cur.hex_rem <= 3'd1) begin
									nxt.hex_rem = 3'd0;
									nxt.phase = key ? PH_KEY_BODY : PH_STR_BODY;
								end else begin
									nxt.hex_rem = cur.hex_rem - 3'd1;
								end
								kind = key ? TK_KEY_BYTE : TK_STR_BYTE;
							end
						end else if (b == CH_QUOTE) begin
							nxt.phase = key ? PH_COLON : PH_AFTER;
							kind = key ? TK_KEY_END : TK_STR_END;
						end else if (b == CH_NUL) begin
							fcode = ST_UNTERM_STR;
						end else begin
							if (b == CH_BSLASH) begin
								nxt.phase = key ? PH_KEY_ESC : PH_STR_ESC;
							end
							kind = key ? TK_KEY_BYTE : TK_STR_BYTE;
						end
					end
					PH_LIT_N, PH_LIT_T, PH_LIT_F: begin
						if (cur.lit_step >= lit_len(lw) || b != lit_char(lw, cur.lit_step)) begin
							fcode = ST_BAD_LIT;
						end else if (cur.lit_step + 3'd1 == lit_len(lw)) begin
							nxt.lit_step = 3'd0;
							nxt.phase = PH_AFTER;
							kind = TK_LIT_DONE;
						end else begin
							nxt.lit_step = cur.lit_step + 3'd1;
							kind = TK_LIT_BYTE;
						end
					end
					PH_AFTER: begin
						after = 1'b1;
					end
					default: begin
						if (is_ws(b)) begin
							kind = TK_WS;
						end else begin
							start = 1'b1;
						end
					end
				endcase
			end

			if (after) begin
				if (is_ws(b)) begin
					kind = TK_WS;
				end else if (at_top) begin
					if (b == CH_NUL) begin
						accepted = 1'b1;
					end else begin
						fcode = ST_TRAILING;
					end
				end else if (b == CH_COMMA) begin
					nxt.phase = top_obj ? PH_KEY : PH_VALUE;
					kind = TK_COMMA;
				end else if (top_obj && b == CH_RBRACE) begin
					op.pop = 1'b1;
					nxt.phase = PH_AFTER;
					kind = TK_OBJ_CLOSE;
				end else if (!top_obj && b == CH_RBRACK) begin
					op.pop = 1'b1;
					nxt.phase = PH_AFTER;
					kind = TK_ARR_CLOSE;
				end else begin
					fcode = top_obj ? ST_EXP_OBJ : ST_EXP_ARR;
				end
			end

			if (start) begin
				if (b == CH_LBRACE || b == CH_LBRACK) begin
					if (at_limit) begin
						fcode = ST_TOO_DEEP;
					end else begin
						op.push = 1'b1;
						op.obj = (b == CH_LBRACE);
						nxt.phase = (b == CH_LBRACE) ? PH_OBJ_FIRST : PH_ARR_FIRST;
						kind = (b == CH_LBRACE) ? TK_OBJ_OPEN : TK_ARR_OPEN;
					end
				end else if (b == CH_QUOTE) begin
					nxt.phase = PH_STR_BODY;
					kind = TK_STR_QUOTE;
				end else if (b == 8'h6E || b == 8'h74 || b == 8'h66) begin
					nxt.phase = (b == 8'h6E) ? PH_LIT_N : ((b == 8'h74) ? PH_LIT_T : PH_LIT_F);
					nxt.lit_step = 3'd1;
					kind = TK_LIT_BYTE;
				end else if (b == CH_MINUS) begin
					nxt.phase = PH_NUM_SIGN;
					kind = TK_NUMBER;
				end else if (is_digit(b)) begin
					nxt.phase = PH_NUM_INT;
					kind = TK_NUMBER;
				end else begin
					fcode = ST_EXP_DIGIT;
				end
			end

			if (fcode != ST_PROGRESS) begin
				nxt.err = fcode;
				kind = TK_WS;
			end
		end

		info.kind   = kind;
		info.ended  = ended;
		info.status = (nxt.err != ST_PROGRESS) ? nxt.err :
			(accepted ? ST_ACCEPTED : ST_PROGRESS);

		// the terminator returns the parse to its starting point
		if (b == CH_NUL) begin
			nxt.phase    = PH_VALUE;
			nxt.lit_step = 3'd0;
			nxt.hex_rem  = 3'd0;
			nxt.err      = ST_PROGRESS;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/json_stream_validator.sv
// json_stream_validator: top level of the streaming JSON syntax checker
// uses jsv_pkg and jsv_step
//
// Input channel text_*: one document byte per beat, byte 0 ends the document.
// Output channel token_*: one token beat per input beat, in order, carrying
// the token kind, the byte itself, the number-ended mark, the nesting depth
// after the byte, the terminator flag and the document status.
// Configuration: the user writes max_nesting with max_nesting_we only while
// the block is idle, unenforced by the block; it resets to 64 and values above
// NEST_STACK_DEPTH act as that depth. Each accepted byte passes the input
// register, then the result register. Throughput is one byte per clock when
// token_stall is low; parse state, level and kind stack update with each byte.
// Reset: arst_n clears control state; the parser waits for the first value at
// top level. After each terminator the parser returns to that same state.
// Stall: while token_stall holds a waiting beat, the input register fills
// once more and text_stall then rises until the result is taken.
`default_nettype none

module json_stream_validator #(
	parameter int NEST_STACK_DEPTH = 64
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       max_nesting_we,
	input  wire logic [6:0] max_nesting,
	input  wire logic       text_valid,
	output logic            text_stall,
	input  wire logic [7:0] text_byte,
	output logic            token_valid,
	input  wire logic       token_stall,
	output logic [3:0]      token_kind,
	output logic [7:0]      byte_echo,
	output logic            number_ended,
	output logic [6:0]      nest_depth,
	output logic            doc_done,
	output logic [3:0]      status
);
	import jsv_pkg::*;

	localparam int LW = $clog2(NEST_STACK_DEPTH + 1);
	localparam int CW = (LW > 7) ? LW : 7;

	logic [6:0]                  max_nesting_q;
	logic                        valid_s1;
	logic [7:0]                  byte_s1;
	parse_state_t                st_q;
	logic [LW-1:0]               level_q;
	logic [NEST_STACK_DEPTH-1:0] kinds_q;

	logic                        token_valid_q;
	logic [3:0]                  token_kind_q;
	logic [7:0]                  byte_echo_q;
	logic                        number_ended_q;
	logic [6:0]                  nest_depth_q;
	logic                        doc_done_q;
	logic [3:0]                  status_q;

	logic                        adv;
	logic                        load;
	logic                        at_top;
	logic                        at_limit;
	logic [CW-1:0]               lim;
	logic [CW-1:0]               mn_w;
	logic [CW-1:0]               dep_w;
	parse_state_t                st_nxt;
	nest_op_t                    op;
	token_info_t                 info;
	logic [LW-1:0]               level_after;

	assign adv        = valid_s1 && (!token_valid_q || !token_stall);
	assign text_stall = valid_s1 && !adv;
	assign load       = text_valid && !text_stall;

	assign at_top   = (level_q == '0);
	assign mn_w     = CW'(max_nesting_q);
	assign dep_w    = CW'(NEST_STACK_DEPTH);
	assign lim      = (mn_w > dep_w) ? dep_w : mn_w;
	assign at_limit = (CW'(level_q) >= lim);

	jsv_step u_step (
		.text_byte (byte_s1),
		.cur       (st_q),
		.at_top    (at_top),
		.at_limit  (at_limit),
		.top_obj   (kinds_q[0]),
		.nxt       (st_nxt),
		.op        (op),
		.info      (info)
	);

	always_comb begin
		level_after = level_q;
		if (op.push) begin
			level_after = level_q + LW'(1);
		end else if (op.pop && !at_top) begin
			level_after = level_q - LW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_nesting_q <= 7'd64;
		end else if (max_nesting_we) begin
			max_nesting_q <= max_nesting;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_s1 <= text_byte;
		end
	end

	// parse state and nesting level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= '{phase: PH_VALUE, lit_step: 3'd0, hex_rem: 3'd0, err: ST_PROGRESS};
			level_q <= '0;
		end else if (adv) begin
			st_q    <= st_nxt;
			level_q <= (byte_s1 == CH_NUL) ? '0 : level_after;
		end
	end

	// kind stack, top of stack at bit 0, 1 for object
	always_ff @(posedge clk) begin
		if (adv && op.push) begin
			kinds_q <= (kinds_q << 1) | NEST_STACK_DEPTH'(op.obj);
		end else if (adv && op.pop) begin
			kinds_q <= kinds_q >> 1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			token_valid_q <= 1'b0;
		end else if (adv) begin
			token_valid_q <= 1'b1;
		end else if (!token_stall) begin
			token_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			token_kind_q   <= info.kind;
			byte_echo_q    <= byte_s1;
			number_ended_q <= info.ended;
			nest_depth_q   <= 7'(level_after);
			doc_done_q     <= (byte_s1 == CH_NUL);
			status_q       <= info.status;
		end
	end

	assign token_valid  = token_valid_q;
	assign token_kind   = token_kind_q;
	assign byte_echo    = byte_echo_q;
	assign number_ended = number_ended_q;
	assign nest_depth   = nest_depth_q;
	assign doc_done     = doc_done_q;
	assign status       = status_q;

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CW'(level_q) <= dep_w)
		else $error("nesting level beyond stack depth");

	a_term_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv && byte_s1 == CH_NUL |=> level_q == '0 && st_q.phase == PH_VALUE &&
			st_q.err == ST_PROGRESS)
		else $error("terminator did not restart the parse");

	a_err_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		token_valid_q && status_q >= ST_BAD_LIT |-> token_kind_q == TK_WS)
		else $error("error beat with a live token kind");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		adv && op.push |-> CW'(level_q) < lim)
		else $error("push past the nesting limit");

endmodule

`default_nettype wire

// File: test/json_stream_validator_test.sv
// json_stream_validator_test: self-checking testbench for the streaming JSON validator
// needs jsv_pkg and json_stream_validator; predicts every token beat and checks it in order
`default_nettype none

module json_stream_validator_test;
	import jsv_pkg::*;

	localparam int STACK_DEPTH = 64;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int RANDOM_LIVE_BYTES = 500;
	localparam int NOISE_BYTES = 200;

	typedef struct packed {
		logic [3:0] kind;
		logic [7:0] echo;
		logic       ended;
		logic [6:0] depth;
		logic       done;
		logic [3:0] status;
	} tok_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       max_nesting_we = 1'b0;
	logic [6:0] max_nesting = 7'd64;
	logic       text_valid = 1'b0;
	logic       text_stall;
	logic [7:0] text_byte = 8'h00;
	logic       token_valid;
	logic       token_stall = 1'b0;
	logic [3:0] token_kind;
	logic [7:0] byte_echo;
	logic       number_ended;
	logic [6:0] nest_depth;
	logic       doc_done;
	logic [3:0] status;

	// parser model state
	logic [4:0]             parse_ph;
	logic [STACK_DEPTH-1:0] obj_stack;
	int                     depth_lvl;
	int                     lit_pos;
	int                     hex_left;
	logic [3:0]             err_code;
	int                     nest_limit = 64;
	string                  lit_words [3] = '{"null", "true", "false"};

	tok_t       expected_tokens [$];
	logic [7:0] doc_q [$];
	logic       gen_obj [$];
	int         gen_left [$];
	logic       gen_first [$];
	int         mismatch_cnt = 0;
	int         cycle_cnt = 0;
	int         live_bytes = 0;
	int         send_idle_pct = 0;
	int         stall_pct = 0;
	int         stall_left = 0;

	json_stream_validator #(
		.NEST_STACK_DEPTH(STACK_DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.max_nesting_we(max_nesting_we),
		.max_nesting(max_nesting),
		.text_valid(text_valid),
		.text_stall(text_stall),
		.text_byte(text_byte),
		.token_valid(token_valid),
		.token_stall(token_stall),
		.token_kind(token_kind),
		.byte_echo(byte_echo),
		.number_ended(number_ended),
		.nest_depth(nest_depth),
		.doc_done(doc_done),
		.status(status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic space_char(input logic [7:0] b);
		return b == 8'h20 || b == 8'h09 || b == 8'h0D || b == 8'h0A;
	endfunction

	function automatic logic dec_char(input logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic logic hex_char(input logic [7:0] b);
		return dec_char(b) || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
	endfunction

	function automatic void clear_parse();
		parse_ph = PH_VALUE;
		obj_stack = '0;
		depth_lvl = 0;
		lit_pos = 0;
		hex_left = 0;
		err_code = ST_PROGRESS;
	endfunction

	function automatic logic [3:0] set_error(input logic [3:0] code);
		err_code = code;
		return TK_WS;
	endfunction

	function automatic logic [3:0] open_level(input logic obj);
		int lim;
		lim = (nest_limit > STACK_DEPTH) ? STACK_DEPTH : nest_limit;
		if (depth_lvl >= lim)
			return set_error(ST_TOO_DEEP);
		obj_stack[depth_lvl] = obj;
		depth_lvl++;
		parse_ph = obj ? PH_OBJ_FIRST : PH_ARR_FIRST;
		return obj ? TK_OBJ_OPEN : TK_ARR_OPEN;
	endfunction

	function automatic logic [3:0] close_level(input logic [3:0] kind);
		if (depth_lvl > 0)
			depth_lvl--;
		parse_ph = PH_AFTER;
		return kind;
	endfunction

	function automatic logic [3:0] begin_value(input logic [7:0] b);
		case (b)
			CH_LBRACE: return open_level(1'b1);
			CH_LBRACK: return open_level(1'b0);
			CH_QUOTE: begin
				parse_ph = PH_STR_BODY;
				return TK_STR_QUOTE;
			end
			"n", "t", "f": begin
				parse_ph = (b == "n") ? PH_LIT_N : (b == "t") ? PH_LIT_T : PH_LIT_F;
				lit_pos = 1;
				return TK_LIT_BYTE;
			end
			CH_MINUS: begin
				parse_ph = PH_NUM_SIGN;
				return TK_NUMBER;
			end
			default: ;
		endcase
		if (dec_char(b)) begin
			parse_ph = PH_NUM_INT;
			return TK_NUMBER;
		end
		return set_error(ST_EXP_DIGIT);
	endfunction

	function automatic logic [3:0] string_byte(input logic [7:0] b, input logic [4:0] p,
			input logic key);
		logic [4:0] body;
		logic [3:0] byte_tk;
		body = key ? PH_KEY_BODY : PH_STR_BODY;
		byte_tk = key ? TK_KEY_BYTE : TK_STR_BYTE;
		if (p == PH_KEY_ESC || p == PH_STR_ESC) begin
			if (b == CH_QUOTE || b == CH_BSLASH || b == CH_SLASH || b == "b" || b == "f" ||
					b == "n" || b == "r" || b == "t") begin
				parse_ph = body;
				return byte_tk;
			end
			if (b == "u") begin
				parse_ph = key ? PH_KEY_HEX : PH_STR_HEX;
				hex_left = 4;
				return byte_tk;
			end
			return set_error(ST_BAD_ESC);
		end
		if (p == PH_KEY_HEX || p == PH_STR_HEX) begin
			if (!hex_char(b))
				return set_error(ST_BAD_HEX);
			if (hex_left <= 1) begin
				hex_left = 0;
				parse_ph = body;
			end else begin
				hex_left--;
			end
			return byte_tk;
		end
		if (b == CH_QUOTE) begin
			parse_ph = key ? PH_COLON : PH_AFTER;
			return key ? TK_KEY_END : TK_STR_END;
		end
		if (b == CH_NUL)
			return set_error(ST_UNTERM_STR);
		if (b == CH_BSLASH)
			parse_ph = key ? PH_KEY_ESC : PH_STR_ESC;
		return byte_tk;
	endfunction

	function automatic logic [3:0] literal_byte(input logic [7:0] b, input logic [4:0] p);
		string word;
		word = lit_words[p - PH_LIT_N];
		if (lit_pos >= word.len() || b != word[lit_pos])
			return set_error(ST_BAD_LIT);
		lit_pos++;
		if (lit_pos == word.len()) begin
			lit_pos = 0;
			parse_ph = PH_AFTER;
			return TK_LIT_DONE;
		end
		return TK_LIT_BYTE;
	endfunction

	function automatic logic [3:0] follow_value(input logic [7:0] b, output logic acc);
		logic in_obj;
		acc = 1'b0;
		if (space_char(b))
			return TK_WS;
		if (depth_lvl == 0) begin
			if (b == CH_NUL) begin
				acc = 1'b1;
				return TK_WS;
			end
			return set_error(ST_TRAILING);
		end
		in_obj = obj_stack[depth_lvl-1];
		if (b == CH_COMMA) begin
			parse_ph = in_obj ? PH_KEY : PH_VALUE;
			return TK_COMMA;
		end
		if (in_obj && b == CH_RBRACE)
			return close_level(TK_OBJ_CLOSE);
		if (!in_obj && b == CH_RBRACK)
			return close_level(TK_ARR_CLOSE);
		return set_error(in_obj ? ST_EXP_OBJ : ST_EXP_ARR);
	endfunction

	function automatic logic [3:0] advance_phase(input logic [7:0] b, output logic ended,
			output logic acc);
		logic [4:0] p;
		ended = 1'b0;
		acc = 1'b0;
		p = parse_ph;
		if (p == PH_NUM_SIGN || p == PH_NUM_EXPSIGN) begin
			if (!dec_char(b))
				return set_error(ST_EXP_DIGIT);
			parse_ph = (p == PH_NUM_SIGN) ? PH_NUM_INT : PH_NUM_EXPDIG;
			return TK_NUMBER;
		end
		if (p == PH_NUM_EXP) begin
			if (b == CH_PLUS || b == CH_MINUS) begin
				parse_ph = PH_NUM_EXPSIGN;
				return TK_NUMBER;
			end
			if (dec_char(b)) begin
				parse_ph = PH_NUM_EXPDIG;
				return TK_NUMBER;
			end
			return set_error(ST_EXP_DIGIT);
		end
		if (p == PH_NUM_INT || p == PH_NUM_FRAC || p == PH_NUM_EXPDIG) begin
			if (dec_char(b))
				return TK_NUMBER;
			if (p == PH_NUM_INT && b == CH_DOT) begin
				parse_ph = PH_NUM_FRAC;
				return TK_NUMBER;
			end
			if (p != PH_NUM_EXPDIG && (b == CH_LOW_E || b == CH_UP_E)) begin
				parse_ph = PH_NUM_EXP;
				return TK_NUMBER;
			end
			// number finished, this byte is handled as whatever follows a value
			ended = 1'b1;
			parse_ph = PH_AFTER;
			p = PH_AFTER;
		end
		case (p)
			PH_ARR_FIRST: begin
				if (space_char(b))
					return TK_WS;
				if (b == CH_RBRACK)
					return close_level(TK_ARR_CLOSE);
				return begin_value(b);
			end
			PH_OBJ_FIRST, PH_KEY: begin
				if (space_char(b))
					return TK_WS;
				if (p == PH_OBJ_FIRST && b == CH_RBRACE)
					return close_level(TK_OBJ_CLOSE);
				if (b == CH_QUOTE) begin
					parse_ph = PH_KEY_BODY;
					return TK_KEY_QUOTE;
				end
				return set_error(ST_EXP_KEY);
			end
			PH_COLON: begin
				if (space_char(b))
					return TK_WS;
				if (b == CH_COLON) begin
					parse_ph = PH_VALUE;
					return TK_COLON;
				end
				return set_error(ST_EXP_COLON);
			end
			PH_KEY_BODY, PH_KEY_ESC, PH_KEY_HEX: return string_byte(b, p, 1'b1);
			PH_STR_BODY, PH_STR_ESC, PH_STR_HEX: return string_byte(b, p, 1'b0);
			PH_LIT_N, PH_LIT_T, PH_LIT_F: return literal_byte(b, p);
			PH_AFTER: return follow_value(b, acc);
			default: begin
				if (space_char(b))
					return TK_WS;
				return begin_value(b);
			end
		endcase
	endfunction

	function automatic tok_t predict_token(input logic [7:0] b);
		tok_t t;
		logic ended, acc;
		t.kind = TK_WS;
		ended = 1'b0;
		acc = 1'b0;
		if (err_code == ST_PROGRESS)
			t.kind = advance_phase(b, ended, acc);
		if (err_code != ST_PROGRESS)
			t.status = err_code;
		else
			t.status = acc ? ST_ACCEPTED : ST_PROGRESS;
		t.echo = b;
		t.ended = ended;
		t.depth = 7'(depth_lvl);
		t.done = (b == CH_NUL);
		if (b == CH_NUL)
			clear_parse();
		return t;
	endfunction

	// pacing
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return $urandom_range(1, 2);
		if (r < 95)
			return $urandom_range(3, 10);
		return $urandom_range(20, 50);
	endfunction

	function automatic int pick_pct();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 10;
			2: return 30;
			default: return 60;
		endcase
	endfunction

	function automatic void pick_pacing();
		send_idle_pct = pick_pct();
		stall_pct = pick_pct();
	endfunction

	// document generation
	function automatic void add_ws();
		if ($urandom_range(0, 3) == 0) begin
			repeat ($urandom_range(1, 2)) begin
				case ($urandom_range(0, 3))
					0: doc_q.push_back(8'h20);
					1: doc_q.push_back(8'h09);
					2: doc_q.push_back(8'h0D);
					default: doc_q.push_back(8'h0A);
				endcase
			end
		end
	endfunction

	function automatic void add_string(input logic key);
		string esc;
		logic [7:0] c;
		esc = "\"\\/bfnrt";
		doc_q.push_back(CH_QUOTE);
		repeat ($urandom_range(0, 5)) begin
			case ($urandom_range(0, 9))
				0: begin
					doc_q.push_back(CH_BSLASH);
					doc_q.push_back(esc[$urandom_range(0, esc.len() - 1)]);
				end
				1: begin
					doc_q.push_back(CH_BSLASH);
					doc_q.push_back("u");
					repeat (4) begin
						c = 8'($urandom_range(0, 21));
						doc_q.push_back((c < 10) ? "0" + c : (c < 16) ? "a" + c - 10 :
							"A" + c - 16);
					end
				end
				2: doc_q.push_back(8'($urandom_range(1, 31)));
				3: doc_q.push_back(8'($urandom_range(128, 255)));
				default: begin
					c = 8'($urandom_range(32, 126));
					doc_q.push_back((c == CH_QUOTE || c == CH_BSLASH) ? "a" : c);
				end
			endcase
		end
		doc_q.push_back(CH_QUOTE);
	endfunction

	function automatic void add_number();
		if ($urandom_range(0, 9) < 3)
			doc_q.push_back(CH_MINUS);
		repeat ($urandom_range(1, 3))
			doc_q.push_back("0" + 8'($urandom_range(0, 9)));
		if ($urandom_range(0, 9) < 3) begin
			doc_q.push_back(CH_DOT);
			repeat ($urandom_range(0, 2))
				doc_q.push_back("0" + 8'($urandom_range(0, 9)));
		end
		if ($urandom_range(0, 3) == 0) begin
			doc_q.push_back($urandom_range(0, 1) ? CH_LOW_E : CH_UP_E);
			case ($urandom_range(0, 2))
				0: doc_q.push_back(CH_PLUS);
				1: doc_q.push_back(CH_MINUS);
				default: ;
			endcase
			repeat ($urandom_range(1, 2))
				doc_q.push_back("0" + 8'($urandom_range(0, 9)));
		end
	endfunction

	function automatic void add_scalar();
		string word;
		case ($urandom_range(0, 2))
			0: add_string(1'b0);
			1: add_number();
			default: begin
				word = lit_words[$urandom_range(0, 2)];
				for (int i = 0; i < word.len(); i++)
					doc_q.push_back(word[i]);
			end
		endcase
	endfunction

	function automatic void add_value(input int max_depth);
		logic obj;
		if (gen_obj.size() < max_depth && $urandom_range(0, 99) < 40) begin
			obj = 1'($urandom_range(0, 1));
			doc_q.push_back(obj ? CH_LBRACE : CH_LBRACK);
			gen_obj.push_back(obj);
			gen_left.push_back($urandom_range(0, 3));
			gen_first.push_back(1'b1);
		end else begin
			add_scalar();
		end
		add_ws();
	endfunction

	// well-formed document without its terminator, nested with an explicit stack
	function automatic void build_document(input int max_depth);
		int top;
		doc_q.delete();
		add_ws();
		add_value(max_depth);
		while (gen_obj.size() != 0) begin
			top = gen_obj.size() - 1;
			if (gen_left[top] == 0) begin
				doc_q.push_back(gen_obj[top] ? CH_RBRACE : CH_RBRACK);
				gen_obj.delete(top);
				gen_left.delete(top);
				gen_first.delete(top);
				add_ws();
			end else begin
				gen_left[top] = gen_left[top] - 1;
				if (!gen_first[top]) begin
					doc_q.push_back(CH_COMMA);
					add_ws();
				end
				gen_first[top] = 1'b0;
				if (gen_obj[top]) begin
					add_string(1'b1);
					add_ws();
					doc_q.push_back(CH_COLON);
					add_ws();
				end
				add_value(max_depth);
			end
		end
	endfunction

	function automatic void damage_document();
		int pos;
		pos = $urandom_range(0, doc_q.size() - 1);
		case ($urandom_range(0, 3))
			0: doc_q[pos] = 8'($urandom_range(0, 255));
			1: begin
				while (doc_q.size() > pos + 1)
					void'(doc_q.pop_back());
			end
			2: doc_q.insert($urandom_range(0, doc_q.size()), 8'($urandom_range(1, 255)));
			default: begin
				if (doc_q.size() > 1)
					doc_q.delete(pos);
			end
		endcase
	endfunction

	function automatic void build_deep(input int levels);
		logic kinds [$];
		doc_q.delete();
		for (int i = 0; i < levels; i++) begin
			kinds.push_back(1'($urandom_range(0, 1)));
			if (kinds[i]) begin
				doc_q.push_back(CH_LBRACE);
				add_string(1'b1);
				doc_q.push_back(CH_COLON);
			end else begin
				doc_q.push_back(CH_LBRACK);
			end
			add_ws();
		end
		add_scalar();
		for (int i = levels - 1; i >= 0; i--)
			doc_q.push_back(kinds[i] ? CH_RBRACE : CH_RBRACK);
		doc_q.push_back(CH_NUL);
	endfunction

	// driving
	task automatic send_byte(input logic [7:0] b);
		if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
			text_valid <= 1'b0;
			repeat (pick_gap()) @(posedge clk);
		end
		text_valid <= 1'b1;
		text_byte <= b;
		do
			@(posedge clk);
		while (text_stall);
		if (err_code == ST_PROGRESS)
			live_bytes++;
		expected_tokens.push_back(predict_token(b));
	endtask

	task automatic send_document();
		for (int i = 0; i < doc_q.size(); i++)
			send_byte(doc_q[i]);
	endtask

	task automatic wait_drained();
		text_valid <= 1'b0;
		while (expected_tokens.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_max_nesting(input logic [6:0] v);
		wait_drained();
		max_nesting_we <= 1'b1;
		max_nesting <= v;
		@(posedge clk);
		max_nesting_we <= 1'b0;
		nest_limit = v;
	endtask

	// tests
	task automatic test_directed_document();
		string text;
		text = "{\"\\u00fF\": [-0e+1,1.,true]}";
		doc_q.delete();
		for (int i = 0; i < text.len(); i++)
			doc_q.push_back(text[i]);
		doc_q.push_back(CH_NUL);
		doc_q.push_back(8'hFF);
		doc_q.push_back(CH_NUL);
		send_document();
	endtask

	task automatic test_nesting_limit();
		logic [6:0] limits [4];
		int eff;
		limits = '{7'd1, 7'd2, 7'd0, 7'd127};
		foreach (limits[i]) begin
			write_max_nesting(limits[i]);
			pick_pacing();
			eff = (limits[i] > STACK_DEPTH) ? STACK_DEPTH : limits[i];
			for (int d = (eff > 0) ? eff : 1; d <= eff + 1; d++) begin
				build_deep(d);
				send_document();
			end
		end
	endtask

	task automatic test_random_documents();
		int n_docs;
		n_docs = 0;
		live_bytes = 0;
		while (live_bytes < RANDOM_LIVE_BYTES) begin
			if (n_docs % 30 == 0) begin
				write_max_nesting(($urandom_range(0, 3) == 0) ? 7'($urandom_range(1, 4)) :
					7'($urandom_range(5, 64)));
				pick_pacing();
			end
			build_document($urandom_range(1, 5));
			if ($urandom_range(0, 99) < 25)
				damage_document();
			doc_q.push_back(CH_NUL);
			send_document();
			n_docs++;
		end
	endtask

	task automatic test_byte_noise();
		pick_pacing();
		doc_q.delete();
		repeat (NOISE_BYTES)
			doc_q.push_back(($urandom_range(0, 99) < 8) ? CH_NUL : 8'($urandom_range(0, 255)));
		doc_q.push_back(CH_NUL);
		send_document();
	endtask

	// output stall
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			token_stall <= 1'b1;
		end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
			stall_left = pick_gap() - 1;
			token_stall <= 1'b1;
		end else begin
			token_stall <= 1'b0;
		end
	end

	function automatic void note_mismatch(input string what, input tok_t want, input tok_t got);
		mismatch_cnt++;
		if (mismatch_cnt <= 10)
			$display("%s: expected kind %0d byte %02h ended %0b depth %0d done %0b status %0d,",
				what, want.kind, want.echo, want.ended, want.depth, want.done, want.status,
				" got kind %0d byte %02h ended %0b depth %0d done %0b status %0d",
				got.kind, got.echo, got.ended, got.depth, got.done, got.status);
	endfunction

	always @(posedge clk) begin
		tok_t got, want;
		if (arst_n && token_valid === 1'b1 && !token_stall) begin
			got.kind = token_kind;
			got.echo = byte_echo;
			got.ended = number_ended;
			got.depth = nest_depth;
			got.done = doc_done;
			got.status = status;
			if (expected_tokens.size() == 0) begin
				note_mismatch("unexpected token beat", '0, got);
			end else begin
				want = expected_tokens.pop_front();
				if (got !== want)
					note_mismatch("token beat mismatch", want, got);
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		clear_parse();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_document();
		test_nesting_limit();
		test_random_documents();
		test_byte_noise();
		wait_drained();
		repeat (10) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

`default_nettype wire

// File: files.f
rtl/core/jsv_pkg.sv
rtl/core/jsv_step.sv
rtl/core/json_stream_validator.sv
test/json_stream_validator_test.sv
